>>> design/pwo_pkg.sv
// Shared types and constants for the pulsar wavetable oscillator.
`timescale 1ns / 1ps
package pwo_pkg;
    localparam int FRAC_BITS = 20;

    localparam logic [3:0] REG_FREQ = 4'd0;
    localparam logic [3:0] REG_MOD = 4'd1;
    localparam logic [3:0] REG_MORPH = 4'd2;
    localparam logic [3:0] REG_WAVES = 4'd3;
    localparam logic [3:0] REG_WINDOWS = 4'd4;
    localparam logic [3:0] REG_PATTERN = 4'd5;
    localparam logic [3:0] REG_LENGTH = 4'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIDTH_A,
        ST_WIDTH_B,
        ST_WIDTH_L,
        ST_DIV,
        ST_MORPH_A,
        ST_MORPH_B,
        ST_MORPH_L,
        ST_STACK_A,
        ST_STACK_B,
        ST_STACK_L,
        ST_XFADE,
        ST_MULT,
        ST_OUT
    } state_t;

    // Datapath operation requested by the controller for the current cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_RD_WIDTH,
        OP_LERP_WIDTH,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_RD_MORPH,
        OP_LERP_MORPH,
        OP_RD_STACK,
        OP_LERP_STACK,
        OP_XFADE,
        OP_MULT,
        OP_ADVANCE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] sub;     // which of the four stack reads: {window, hi}
        logic       phase_b; // second read of an interpolation pair
    } cmd_t;

    typedef struct packed {
        logic active;  // pulse width positive and burst slot enabled
        logic div_done;
    } status_t;
endpackage

>>> design/pwo_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module pwo_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic             in_mode,
    input  logic             out_busy,
    input  pwo_pkg::status_t stat,
    output pwo_pkg::cmd_t    cmd,
    output logic             in_free,
    output logic             out_load
);
    pwo_pkg::state_t state_reg, state_next;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwo_pkg::ST_IDLE;
            sub_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next = sub_reg;
        case (state_reg)
            pwo_pkg::ST_IDLE:
                if (in_fire && !in_mode) state_next = pwo_pkg::ST_WIDTH_A;
            pwo_pkg::ST_WIDTH_A: state_next = pwo_pkg::ST_WIDTH_B;
            pwo_pkg::ST_WIDTH_B: state_next = pwo_pkg::ST_WIDTH_L;
            pwo_pkg::ST_WIDTH_L:
                state_next = stat.active ? pwo_pkg::ST_DIV : pwo_pkg::ST_MULT;
            pwo_pkg::ST_DIV:
                if (stat.div_done) state_next = pwo_pkg::ST_MORPH_A;
            pwo_pkg::ST_MORPH_A: state_next = pwo_pkg::ST_MORPH_B;
            pwo_pkg::ST_MORPH_B: state_next = pwo_pkg::ST_MORPH_L;
            pwo_pkg::ST_MORPH_L:
            begin
                state_next = pwo_pkg::ST_STACK_A;
                sub_next = 2'd0;
            end
            pwo_pkg::ST_STACK_A: state_next = pwo_pkg::ST_STACK_B;
            pwo_pkg::ST_STACK_B: state_next = pwo_pkg::ST_STACK_L;
            pwo_pkg::ST_STACK_L:
            begin
                sub_next = sub_reg + 2'd1;
                state_next = (sub_reg == 2'd3) ? pwo_pkg::ST_XFADE : pwo_pkg::ST_STACK_A;
            end
            pwo_pkg::ST_XFADE: state_next = pwo_pkg::ST_MULT;
            pwo_pkg::ST_MULT: state_next = pwo_pkg::ST_OUT;
            pwo_pkg::ST_OUT:
                if (!out_busy) state_next = pwo_pkg::ST_IDLE;
            default: state_next = pwo_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = pwo_pkg::OP_NONE;
        cmd.sub = sub_reg;
        cmd.phase_b = 1'b0;
        in_free = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            pwo_pkg::ST_IDLE:
            begin
                in_free = 1'b1;
                if (in_fire && in_mode) cmd.op = pwo_pkg::OP_WRITE;
            end
            pwo_pkg::ST_WIDTH_A: cmd.op = pwo_pkg::OP_RD_WIDTH;
            pwo_pkg::ST_WIDTH_B:
            begin
                cmd.op = pwo_pkg::OP_RD_WIDTH;
                cmd.phase_b = 1'b1;
            end
            pwo_pkg::ST_WIDTH_L: cmd.op = pwo_pkg::OP_LERP_WIDTH;
            pwo_pkg::ST_DIV:
                cmd.op = stat.div_done ? pwo_pkg::OP_NONE : pwo_pkg::OP_DIV_STEP;
            pwo_pkg::ST_MORPH_A: cmd.op = pwo_pkg::OP_RD_MORPH;
            pwo_pkg::ST_MORPH_B:
            begin
                cmd.op = pwo_pkg::OP_RD_MORPH;
                cmd.phase_b = 1'b1;
            end
            pwo_pkg::ST_MORPH_L: cmd.op = pwo_pkg::OP_LERP_MORPH;
            pwo_pkg::ST_STACK_A: cmd.op = pwo_pkg::OP_RD_STACK;
            pwo_pkg::ST_STACK_B:
            begin
                cmd.op = pwo_pkg::OP_RD_STACK;
                cmd.phase_b = 1'b1;
            end
            pwo_pkg::ST_STACK_L: cmd.op = pwo_pkg::OP_LERP_STACK;
            pwo_pkg::ST_XFADE: cmd.op = pwo_pkg::OP_XFADE;
            pwo_pkg::ST_MULT: cmd.op = pwo_pkg::OP_MULT;
            pwo_pkg::ST_OUT:
                if (!out_busy)
                begin
                    cmd.op = pwo_pkg::OP_ADVANCE;
                    out_load = 1'b1;
                end
            default: cmd.op = pwo_pkg::OP_NONE;
        endcase
    end
endmodule

>>> design/pwo_datapath.sv
// Datapath: table memories, phases, divider, interpolation and output math.
`timescale 1ns / 1ps
module pwo_datapath
#(
    parameter int TABLE_LEN = 4096,
    parameter int NUM_WAVES = 4,
    parameter int NUM_WINDOWS = 3,
    parameter int NUM_BURST = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  pwo_pkg::cmd_t    cmd,
    output pwo_pkg::status_t stat,
    input  logic [3:0]       table_select,
    input  logic [11:0]      table_index,
    input  logic [15:0]      table_value,
    input  logic [31:0]      freq_inc,
    input  logic [31:0]      mod_inc,
    input  logic [31:0]      morph_inc,
    input  logic [2:0]       waves_use,
    input  logic [1:0]       windows_use,
    input  logic [3:0]       pattern,
    input  logic [2:0]       blen,
    output logic [15:0]      sample
);
    localparam int AW = $clog2(TABLE_LEN);
    localparam int WAVE_AW = $clog2(NUM_WAVES * TABLE_LEN);
    localparam int WIN_AW = $clog2(NUM_WINDOWS * TABLE_LEN);
    localparam int POSW = 48;
    localparam logic [32:0] BOUND = 33'(TABLE_LEN - 1) << pwo_pkg::FRAC_BITS;
    localparam int SEL_WIDTH = NUM_WAVES + NUM_WINDOWS;

    logic [15:0] wave_mem [NUM_WAVES * TABLE_LEN];
    logic [15:0] win_mem [NUM_WINDOWS * TABLE_LEN];
    logic [15:0] width_mem [TABLE_LEN];
    logic [15:0] morph_mem [TABLE_LEN];

    logic [31:0] main_ph_reg, width_ph_reg, morph_ph_reg;
    logic [1:0] burst_reg;
    logic [POSW-1:0] pos_reg;
    logic [47:0] rem_reg;
    logic [5:0] div_cnt_reg;
    logic div_done_reg;
    logic signed [15:0] ea_reg, wave_rd, win_rd, width_rd, morph_rd;
    logic signed [16:0] pw_reg, morph_reg;
    logic signed [16:0] lv_reg [4];
    logic signed [16:0] wv_reg, wn_reg;
    logic [15:0] out_reg;

    // Effective burst length and stack counts.
    logic [2:0] len_eff;
    logic [4:0] nwv, nwn;
    always_comb
    begin
        len_eff = blen;
        if (32'(len_eff) > NUM_BURST) len_eff = 3'(NUM_BURST);
        if (len_eff > 3'd4) len_eff = 3'd4;
        nwv = (waves_use == 3'd0) ? 5'd1 : 5'(waves_use);
        if (32'(nwv) > NUM_WAVES) nwv = 5'(NUM_WAVES);
        nwn = (windows_use == 2'd0) ? 5'd1 : 5'(windows_use);
        if (32'(nwn) > NUM_WINDOWS) nwn = 5'(NUM_WINDOWS);
    end

    // Stack index for the current sub read.
    logic [4:0] ncnt;
    logic [20:0] scaled;
    logic [5:0] lo, hi, tix;
    always_comb
    begin
        ncnt = cmd.sub[1] ? nwn : nwv;
        scaled = 21'(morph_reg[15:0]) * 21'((ncnt > 5'd2) ? ncnt - 5'd1 : 5'd1);
        lo = 6'(scaled >> 15);
        hi = lo + 6'd1;
        if (lo > 6'(ncnt - 5'd1)) lo = 6'(ncnt - 5'd1);
        if (hi > 6'(ncnt - 5'd1)) hi = 6'(ncnt - 5'd1);
        tix = cmd.sub[0] ? hi : lo;
    end

    // Read addresses.
    logic [31:0] rd_phase;
    logic [AW-1:0] ia, ib, rd_addr;
    logic [19:0] frac;
    always_comb
    begin
        case (cmd.op)
            pwo_pkg::OP_RD_WIDTH, pwo_pkg::OP_LERP_WIDTH: rd_phase = width_ph_reg;
            pwo_pkg::OP_RD_MORPH, pwo_pkg::OP_LERP_MORPH: rd_phase = morph_ph_reg;
            default: rd_phase = pos_reg[31:0];
        endcase
        ia = AW'(((cmd.op == pwo_pkg::OP_RD_STACK || cmd.op == pwo_pkg::OP_LERP_STACK)
                  ? pos_reg[POSW-1:20] : 28'(rd_phase[31:20])) % TABLE_LEN);
        ib = AW'((32'(ia) + 32'd1) % TABLE_LEN);
        rd_addr = cmd.phase_b ? ib : ia;
        frac = rd_phase[19:0];
    end

    // Flat addresses into the wave and window stacks.
    logic [WAVE_AW-1:0] wave_wa, wave_ra;
    logic [WIN_AW-1:0] win_wa, win_ra;
    always_comb
    begin
        wave_wa = WAVE_AW'(32'(table_select) * TABLE_LEN + 32'(table_index));
        win_wa = WIN_AW'((32'(table_select) - NUM_WAVES) * TABLE_LEN + 32'(table_index));
        wave_ra = WAVE_AW'(32'(tix) * TABLE_LEN + 32'(rd_addr));
        win_ra = WIN_AW'(32'(tix) * TABLE_LEN + 32'(rd_addr));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == pwo_pkg::OP_WRITE && 32'(table_index) < TABLE_LEN)
        begin
            if (32'(table_select) < NUM_WAVES)
                wave_mem[wave_wa] <= table_value;
            else if (32'(table_select) < SEL_WIDTH)
                win_mem[win_wa] <= table_value;
            else if (32'(table_select) == SEL_WIDTH)
                width_mem[AW'(table_index)] <= table_value;
            else if (32'(table_select) == SEL_WIDTH + 1)
                morph_mem[AW'(table_index)] <= table_value;
        end
        wave_rd <= wave_mem[wave_ra];
        win_rd <= win_mem[win_ra];
        width_rd <= width_mem[rd_addr];
        morph_rd <= morph_mem[rd_addr];
    end

    // Memory data selected for the read issued in the previous cycle.
    pwo_pkg::op_t op_q;
    logic sub1_q;
    logic signed [15:0] rd_data;
    always_ff @(posedge clk)
    begin
        op_q <= cmd.op;
        sub1_q <= cmd.sub[1];
    end
    always_comb
    begin
        case (op_q)
            pwo_pkg::OP_RD_WIDTH: rd_data = width_rd;
            pwo_pkg::OP_RD_MORPH: rd_data = morph_rd;
            default: rd_data = sub1_q ? win_rd : wave_rd;
        endcase
    end

    // Linear interpolation of the latched pair, taken from the registered reads.
    logic signed [15:0] la, lb;
    logic signed [37:0] lsum;
    logic signed [16:0] lres;
    always_comb
    begin
        la = ea_reg;
        lb = rd_data;
        lsum = 38'(la) * $signed({1'b0, 21'h100000 - 21'(frac)})
             + 38'(lb) * $signed({2'b0, frac});
        lres = 17'(lsum >>> 20);
    end

    // Crossfade of each stack at its own morph fraction.
    logic [20:0] scaled_wv, scaled_wn;
    always_comb
    begin
        scaled_wv = 21'(morph_reg[15:0]) * 21'((nwv > 5'd2) ? nwv - 5'd1 : 5'd1);
        scaled_wn = 21'(morph_reg[15:0]) * 21'((nwn > 5'd2) ? nwn - 5'd1 : 5'd1);
    end
    logic signed [33:0] xw2, xn2;
    logic signed [16:0] gw, gn;
    always_comb
    begin
        gw = $signed({2'b0, 15'(scaled_wv)});
        gn = $signed({2'b0, 15'(scaled_wn)});
        xw2 = 34'(lv_reg[0]) * 34'(17'sd32768 - gw) + 34'(lv_reg[1]) * 34'(gw);
        xn2 = 34'(lv_reg[2]) * 34'(17'sd32768 - gn) + 34'(lv_reg[3]) * 34'(gn);
    end

    logic signed [33:0] prod;
    logic signed [18:0] prs;
    always_comb
    begin
        prod = 34'(wv_reg) * 34'(wn_reg);
        prs = 19'(prod >>> 15);
    end

    // Phase advance.
    function automatic logic [32:0] adv(input logic [31:0] p, input logic [31:0] inc);
        logic [32:0] s;
        s = 33'(p) + 33'(inc);
        if (s >= BOUND) s = s - BOUND;
        return s;
    endfunction
    logic [32:0] main_s, width_s, morph_s;
    logic main_hit;
    logic [2:0] bp;
    always_comb
    begin
        main_s = adv(main_ph_reg, freq_inc);
        main_hit = (33'(main_ph_reg) + 33'(freq_inc)) >= BOUND;
        width_s = adv(width_ph_reg, mod_inc);
        morph_s = adv(morph_ph_reg, morph_inc);
        bp = 3'(burst_reg) + 3'd1;
        if (bp >= len_eff - 3'd1) bp = bp - (len_eff - 3'd1);
    end

    // Restoring divider: (main_phase << 15) / pw, one quotient bit per cycle.
    logic [47:0] trial;
    logic [47:0] dividend;
    always_comb
    begin
        dividend = {1'b0, main_ph_reg, 15'd0};
        trial = {rem_reg[46:0], dividend[6'd47 - div_cnt_reg]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_ph_reg <= '0;
            width_ph_reg <= '0;
            morph_ph_reg <= '0;
            burst_reg <= '0;
            div_done_reg <= 1'b0;
            div_cnt_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                pwo_pkg::OP_LERP_WIDTH:
                begin
                    div_cnt_reg <= '0;
                    div_done_reg <= 1'b0;
                end
                pwo_pkg::OP_DIV_STEP:
                begin
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd47) div_done_reg <= 1'b1;
                end
                pwo_pkg::OP_ADVANCE:
                begin
                    main_ph_reg <= main_s[31:0];
                    width_ph_reg <= width_s[31:0];
                    morph_ph_reg <= morph_s[31:0];
                    if (len_eff <= 3'd2) burst_reg <= 2'd0;
                    else if (main_hit) burst_reg <= bp[1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            pwo_pkg::OP_LERP_WIDTH:
            begin
                pw_reg <= lres;
                rem_reg <= '0;
                pos_reg <= '0;
                wv_reg <= '0;
                wn_reg <= '0;
            end
            pwo_pkg::OP_DIV_STEP:
            begin
                if (trial >= 48'(pw_reg[15:0]))
                begin
                    rem_reg <= trial - 48'(pw_reg[15:0]);
                    pos_reg <= {pos_reg[POSW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    pos_reg <= {pos_reg[POSW-2:0], 1'b0};
                end
            end
            pwo_pkg::OP_LERP_MORPH: morph_reg <= (lres < 0) ? 17'sd0 : lres;
            pwo_pkg::OP_LERP_STACK: lv_reg[cmd.sub] <= lres;
            pwo_pkg::OP_XFADE:
            begin
                wv_reg <= (nwv <= 5'd1) ? lv_reg[0] : 17'(xw2 >>> 15);
                wn_reg <= (nwn <= 5'd1) ? lv_reg[2] : 17'(xn2 >>> 15);
            end
            pwo_pkg::OP_MULT:
                out_reg <= (prs > 19'sd32767) ? 16'h7FFF : prs[15:0];
            default: ;
        endcase
        if (cmd.op == pwo_pkg::OP_RD_WIDTH || cmd.op == pwo_pkg::OP_RD_MORPH ||
            cmd.op == pwo_pkg::OP_RD_STACK)
            if (cmd.phase_b) ea_reg <= rd_data;
    end

    // The pulse-width blend is valid while the controller sits in its blend
    // state, which is the only state that looks at this flag.
    assign stat.active = (lres > 17'sd0) && (len_eff <= 3'd2 || pattern[burst_reg]);
    assign stat.div_done = div_done_reg;
    assign sample = out_reg;
endmodule

>>> design/pulsar_wavetable_oscillator_unit.sv
// Top level of the pulsar wavetable oscillator.
`timescale 1ns / 1ps
// Usage: the input channel (in_valid/in_stall) carries one beat per item.
// A beat with mode 1 writes one entry of a wave, window, pulse-width or
// morph table and yields no output. A beat with mode 0 is a tick that
// yields exactly one sample beat on the output channel (out_valid/out_stall).
// After a write the controller stays idle and can take the next beat. An
// audible tick keeps the input closed until its sample is loaded into the
// output register, as out_valid rises. The tick reads and blends the pulse
// width, runs the 48-step restoring divider for phase / pulse width, then
// the morph lookup, the four stack lookups, and the crossfade, product and
// output load. Silent ticks (width not positive or burst slot off) skip
// the divider, the morph and stack reads and the crossfade, and go from the
// width blend straight to the product. The controller handles one
// item at a time; it accepts a new beat while the previous sample still
// waits in the output register. When the receiver stalls, the output beat
// holds and a finished tick waits in its last state until the register
// frees. Reset clears the phases, burst position and control state and
// loads register defaults; table contents are undefined until written.
// Configuration writes (cfg_we, cfg_index, cfg_data) belong in idle time.
module pulsar_wavetable_oscillator_unit
#(
    parameter int TABLE_LEN = 4096,
    parameter int NUM_WAVES = 4,
    parameter int NUM_WINDOWS = 3,
    parameter int NUM_BURST = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [3:0]  table_select,
    input  logic [11:0] table_index,
    input  logic [15:0] table_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] sample_out,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [31:0] freq_reg, mod_reg, morph_reg;
    logic [2:0] waves_reg, blen_reg;
    logic [1:0] windows_reg;
    logic [3:0] pattern_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= 32'd21420909;
            mod_reg <= 32'd2921;
            morph_reg <= 32'd29210;
            waves_reg <= 3'd4;
            windows_reg <= 2'd3;
            pattern_reg <= 4'd11;
            blen_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwo_pkg::REG_FREQ: freq_reg <= cfg_data;
                pwo_pkg::REG_MOD: mod_reg <= cfg_data;
                pwo_pkg::REG_MORPH: morph_reg <= cfg_data;
                pwo_pkg::REG_WAVES: waves_reg <= cfg_data[2:0];
                pwo_pkg::REG_WINDOWS: windows_reg <= cfg_data[1:0];
                pwo_pkg::REG_PATTERN: pattern_reg <= cfg_data[3:0];
                pwo_pkg::REG_LENGTH: blen_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    pwo_pkg::cmd_t cmd;
    pwo_pkg::status_t stat;
    logic in_free, out_load, in_fire;
    logic out_valid_reg;
    logic [15:0] result;

    // The output register is busy while it holds a beat the receiver stalls.
    logic out_busy;
    assign out_busy = out_valid_reg && out_stall;
    assign in_stall = !in_free;
    assign in_fire = in_valid && in_free;

    pwo_ctrl u_ctrl
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(in_fire),
        .in_mode(mode),
        .out_busy(out_busy),
        .stat(stat),
        .cmd(cmd),
        .in_free(in_free),
        .out_load(out_load)
    );

    pwo_datapath
    #(
        .TABLE_LEN(TABLE_LEN),
        .NUM_WAVES(NUM_WAVES),
        .NUM_WINDOWS(NUM_WINDOWS),
        .NUM_BURST(NUM_BURST)
    )
    u_dp
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .stat(stat),
        .table_select(table_select),
        .table_index(table_index),
        .table_value(table_value),
        .freq_inc(freq_reg),
        .mod_inc(mod_reg),
        .morph_inc(morph_reg),
        .waves_use(waves_reg),
        .windows_use(windows_reg),
        .pattern(pattern_reg),
        .blen(blen_reg),
        .sample(result)
    );

    logic [15:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (out_load) out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign sample_out = out_data_reg;
endmodule

>>> design/pwo_checker.sv
// Port-level checker for the oscillator, bound to the top level.
`timescale 1ns / 1ps
module pwo_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] sample_out
);
    // A stalled output beat holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("output beat changed under stall");

    // A write beat never produces a result in the next cycle.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode && !out_valid |=> !out_valid)
        else $error("write produced a sample");

    // A tick keeps the input busy for the following cycle.
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> in_stall)
        else $error("tick accepted without busy");

    // No output beat in the cycle after an accepted tick.
    a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode && !out_valid |=> !out_valid)
        else $error("sample too early");
endmodule

bind pulsar_wavetable_oscillator_unit pwo_checker u_pwo_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out)
);

>>> tb/sv/tb_pulsar_wavetable_oscillator_unit.sv
// Self-checking testbench for the pulsar wavetable oscillator top level.
`timescale 1ns / 1ps
// The run fills every table entry first, so that no tick ever reads an
// entry that was never written. It then sends a short directed set of beats
// and about two thousand random beats. These beats mix ticks with table
// writes, and the writes include selects beyond the morph table. The run
// goes through four idling phases and several register settings, extreme
// values among them. A scoreboard class mirrors the tables, the phases and
// the burst counter. It predicts each tick's sample and compares it with the
// output beats in order.

// Scoreboard: mirror of the oscillator state and queue of expected samples.
class osc_scoreboard;
    localparam int TLEN = 4096;
    localparam int WAVE_BASE = 0;
    localparam int WINDOW_BASE = 4 * TLEN;
    localparam int WIDTH_BASE = 7 * TLEN;
    localparam int MORPH_BASE = 8 * TLEN;
    localparam longint unsigned PHASE_BOUND = 64'd4095 << 20;

    bit [15:0] tables [9 * TLEN];
    bit [31:0] main_ph, width_ph, morph_ph;
    bit [1:0]  burst_pos;
    bit [31:0] freq_inc, mod_inc, morph_inc;
    bit [2:0]  waves_n;
    bit [1:0]  windows_n;
    bit [3:0]  burst_pat;
    bit [2:0]  burst_len;
    bit [15:0] expected_samples [$];
    int        errors;
    int        ticks_seen;
    int        loud_ticks;

    function new();
        main_ph = 0;
        width_ph = 0;
        morph_ph = 0;
        burst_pos = 0;
        freq_inc = 32'd21420909;
        mod_inc = 32'd2921;
        morph_inc = 32'd29210;
        waves_n = 3'd4;
        windows_n = 2'd3;
        burst_pat = 4'd11;
        burst_len = 3'd4;
        errors = 0;
        ticks_seen = 0;
        loud_ticks = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [31:0] data);
        case (idx)
            pwo_pkg::REG_FREQ:    freq_inc = data;
            pwo_pkg::REG_MOD:     mod_inc = data;
            pwo_pkg::REG_MORPH:   morph_inc = data;
            pwo_pkg::REG_WAVES:   waves_n = data[2:0];
            pwo_pkg::REG_WINDOWS: windows_n = data[1:0];
            pwo_pkg::REG_PATTERN: burst_pat = data[3:0];
            pwo_pkg::REG_LENGTH:  burst_len = data[2:0];
            default: ;
        endcase
    endfunction

    // Linear interpolation in one table at a Q.20 position, floor rounding.
    function int interp(int base, longint unsigned pos);
        int i;
        int j;
        longint a;
        longint b;
        longint f;
        longint s;
        i = int'((pos >> 20) % TLEN);
        j = (i + 1) % TLEN;
        f = longint'(pos & 64'hFFFFF);
        a = longint'($signed(tables[base + i]));
        b = longint'($signed(tables[base + j]));
        s = a * (64'sd1048576 - f) + b * f;
        return int'(s >>> 20);
    endfunction

    // Crossfade between two neighboring tables of a stack at morph m.
    function int stack_read(int base, int unsigned n, int m, longint unsigned pos);
        int unsigned mul;
        int unsigned scaled;
        int unsigned lo;
        int unsigned hi;
        longint s;
        if (n <= 1)
            return interp(base, pos);
        mul = (n - 1 > 1) ? n - 1 : 1;
        scaled = int'(m) * mul;
        lo = scaled >> 15;
        hi = lo + 1;
        if (lo > n - 1) lo = n - 1;
        if (hi > n - 1) hi = n - 1;
        s = longint'(interp(base + lo * TLEN, pos)) * (32768 - (scaled & 32'h7FFF))
          + longint'(interp(base + hi * TLEN, pos)) * (scaled & 32'h7FFF);
        return int'(s >>> 15);
    endfunction

    function bit step_phase(inout bit [31:0] ph, input bit [31:0] inc);
        longint unsigned s;
        bit hit;
        s = longint'(ph) + longint'(inc);
        hit = (s >= PHASE_BOUND);
        if (hit) s -= PHASE_BOUND;
        ph = s[31:0];
        return hit;
    endfunction

    function int unsigned stack_count(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        return (v > limit) ? limit : v;
    endfunction

    // Called for every accepted input beat.
    function void note_beat(bit mode, bit [3:0] sel, bit [11:0] idx, bit [15:0] val);
        int unsigned len;
        bit en;
        int pw;
        int m;
        int smp;
        int win;
        longint unsigned pos;
        longint p;
        bit [31:0] p32;
        int v;
        if (mode)
        begin
            if (sel <= 4'd8)
                tables[int'(sel) * TLEN + int'(idx)] = val;
            return;
        end
        ticks_seen++;
        len = (burst_len > 4) ? 4 : burst_len;
        en = (len > 2) ? burst_pat[burst_pos] : 1'b1;
        smp = 0;
        win = 0;
        pw = interp(WIDTH_BASE, width_ph);
        if (pw > 0 && en)
        begin
            loud_ticks++;
            pos = (longint'(main_ph) << 15) / longint'(pw);
            m = interp(MORPH_BASE, morph_ph);
            if (m < 0) m = 0;
            smp = stack_read(WAVE_BASE, stack_count(waves_n, 4), m, pos);
            win = stack_read(WINDOW_BASE, stack_count(windows_n, 3), m, pos);
        end
        if (step_phase(main_ph, freq_inc) && len > 2)
        begin
            burst_pos = burst_pos + 2'd1;
            if (burst_pos >= len - 1) burst_pos = burst_pos - 2'(len - 1);
        end
        if (len <= 2) burst_pos = 0;
        void'(step_phase(width_ph, mod_inc));
        void'(step_phase(morph_ph, morph_inc));
        p = longint'(smp) * longint'(win) + (64'sd1 << 30);
        p32 = p[31:0];
        v = int'(p32 >> 15) - 32768;
        if (v > 32767) v = 32767;
        expected_samples.push_back(v[15:0]);
    endfunction

    // Called for every accepted output beat.
    function void check_sample(bit [15:0] actual);
        bit [15:0] want;
        if (expected_samples.size() == 0)
        begin
            $error("sample_out beat %0d arrived with no tick waiting", $signed(actual));
            errors++;
            return;
        end
        want = expected_samples.pop_front();
        if (want !== actual)
        begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want), $signed(actual));
            errors++;
        end
    endfunction
endclass

module tb_pulsar_wavetable_oscillator_unit;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TLEN = 4096;
    localparam logic [3:0] SEL_WIDTH = 4'd7;
    localparam logic [3:0] SEL_MORPH = 4'd8;
    localparam bit MODE_TICK = 1'b0;
    localparam bit MODE_WRITE = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = 1'b0;
    logic [3:0]  table_select = '0;
    logic [11:0] table_index = '0;
    logic [15:0] table_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] sample_out;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    osc_scoreboard sb = new();

    // Idling percentages for the current phase, and a long receiver hold-off.
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;
    int random_beats = 0;

    pulsar_wavetable_oscillator_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .table_select(table_select),
        .table_index(table_index),
        .table_value(table_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sample_out(sample_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // The watchdog ends a run that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycles, sb.expected_samples.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls at random. A pending hold-off request takes
    // precedence, which lets the block fill up behind a stalled output.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall = 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // An output beat moves at each rising edge where valid is high and stall is low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_sample(sample_out);
    end

    // Offer one input beat and hold it until it is taken. A random gap may follow.
    task automatic send_beat(bit m, bit [3:0] sel, bit [11:0] idx, bit [15:0] val);
        int gap;
        @(negedge clk);
        in_valid = 1'b1;
        mode = m;
        table_select = sel;
        table_index = idx;
        table_value = val;
        do @(posedge clk); while (in_stall);
        sb.note_beat(m, sel, idx, val);
        if ($urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Configuration changes only happen once the block has drained.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_samples.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic apply_setting(bit [31:0] f, bit [31:0] md, bit [31:0] mp,
                                 bit [2:0] wv, bit [1:0] wn, bit [3:0] pat,
                                 bit [2:0] len);
        write_reg(pwo_pkg::REG_FREQ, f);
        write_reg(pwo_pkg::REG_MOD, md);
        write_reg(pwo_pkg::REG_MORPH, mp);
        write_reg(pwo_pkg::REG_WAVES, {29'd0, wv});
        write_reg(pwo_pkg::REG_WINDOWS, {30'd0, wn});
        write_reg(pwo_pkg::REG_PATTERN, {28'd0, pat});
        write_reg(pwo_pkg::REG_LENGTH, {29'd0, len});
    endtask

    // Mostly ticks. Writes use every select, including unused ones, so they
    // keep reshaping the tables while the phases run.
    task automatic random_traffic(int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 70)
                send_beat(MODE_TICK, 4'($urandom), 12'($urandom), 16'($urandom));
            else
                send_beat(MODE_WRITE, 4'($urandom), 12'($urandom), 16'($urandom));
            random_beats++;
        end
    endtask

    initial
    begin
        bit [15:0] w;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill every entry. Most pulse widths are positive, so most ticks are audible.
        for (int s = 0; s <= 8; s++)
        begin
            for (int i = 0; i < TLEN; i++)
            begin
                w = 16'($urandom);
                if (s == SEL_WIDTH && $urandom_range(99) < 75)
                    w = 16'($urandom_range(1, 32767));
                send_beat(MODE_WRITE, 4'(s), 12'(i), w);
            end
        end

        // Directed beats: extreme values and indexes, ignored selects, and
        // ticks with the reset settings.
        send_beat(MODE_WRITE, 4'd0, 12'd0, 16'h8000);
        send_beat(MODE_WRITE, 4'd0, 12'd4095, 16'h7FFF);
        send_beat(MODE_WRITE, 4'd6, 12'd0, 16'h7FFF);
        send_beat(MODE_WRITE, SEL_WIDTH, 12'd0, 16'h7FFF);
        send_beat(MODE_WRITE, SEL_WIDTH, 12'd1, 16'h0000);
        send_beat(MODE_WRITE, SEL_MORPH, 12'd0, 16'h8000);
        send_beat(MODE_WRITE, 4'd15, 12'd4095, 16'hFFFF);
        send_beat(MODE_WRITE, 4'd9, 12'd17, 16'h1234);
        repeat (12) send_beat(MODE_TICK, 4'd0, 12'd0, 16'd0);
        send_beat(MODE_TICK, 4'hF, 12'hFFF, 16'hFFFF);
        drain();

        // No idling; short burst, single tables, zero morph step.
        apply_setting(32'd40000000, 32'd300000, 32'd0, 3'd1, 2'd1, 4'd0, 3'd2);
        random_traffic(300);
        drain();

        // The sender idles. Maximum steps, an oversized wave stack count, and the
        // long-burst setting.
        send_gap_pct = 73;
        apply_setting(32'd4293918719, 32'd4293918719, 32'd4293918719,
                      3'd7, 2'd3, 4'd15, 3'd7);
        random_traffic(350);
        drain();

        // The receiver stalls, including one long hold-off while ticks keep coming.
        send_gap_pct = 0;
        stall_pct = 73;
        apply_setting(32'd0, 32'd0, 32'd123457, 3'd0, 2'd0, 4'd5, 3'd3);
        hold_cycles = 800;
        random_traffic(350);
        drain();

        // Both sides idle; reset-like settings with a partial stack.
        send_gap_pct = 24;
        stall_pct = 24;
        apply_setting(32'd21420909, 32'd2921, 32'd29210, 3'd2, 2'd2, 4'd11, 3'd4);
        random_traffic(350);
        drain();

        // Burst length one, wide steps, no idling; then both sides idle.
        send_gap_pct = 0;
        stall_pct = 0;
        apply_setting(32'd900000000, 32'd77777777, 32'd5000000, 3'd4, 2'd3, 4'd9, 3'd1);
        random_traffic(300);
        drain();
        send_gap_pct = 73;
        stall_pct = 73;
        apply_setting(32'd1048576, 32'd1000, 32'd700000, 3'd3, 2'd2, 4'd6, 3'd0);
        random_traffic(300);
        drain();

        if (sb.expected_samples.size() != 0)
        begin
            $error("%0d expected samples never arrived", sb.expected_samples.size());
            sb.errors++;
        end
        $display("Covered %0d random beats and %0d ticks (%0d audible) over six settings",
                 random_beats, sb.ticks_seen, sb.loud_ticks);
        $display("and four idling phases, after a full table load; %0d errors.", sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
